[rtl/btrie_pkg.sv]
package btrie_pkg;

	typedef enum logic [1:0] {
		KIND_ADD    = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_LOOKUP = 2'd2,
		KIND_NONE   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_NOTFOUND = 2'd1,
		ST_FULL     = 2'd2
	} status_t;

	localparam int HOP_W  = 15;
	localparam int LEN_W  = 6;
	localparam int ADDR_W = 32;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_RD,
		S_WAIT,
		S_STEP,
		S_ALLOC,
		S_SETHOP,
		S_PRUNE_RD,
		S_PRUNE_WAIT,
		S_PRUNE_CHK,
		S_PRUNE_PAR_WAIT,
		S_PRUNE_PAR,
		S_DONE
	} state_t;

endpackage

[rtl/binary_trie_prefix_route_table.sv]
// lookup reads one node per trie level through S_RD, S_WAIT and S_STEP, then passes S_DONE to m_tvalid
// add walks the path twice, allocating each new node through S_ALLOC on the second pass
// delete walks once, then prunes empty nodes level by level through the S_PRUNE_* states
// one item at a time; the next input transfer waits for the result transfer
// reset: after arst_n the block clears NODE_COUNT nodes and fills the free stack,
// one entry per cycle, before s_tready rises
module binary_trie_prefix_route_table #(
	parameter int MAX_PREFIX_LEN = 32,
	parameter int NODE_COUNT     = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// kind[1:0], prefix_bits[33:2], prefix_len[39:34], next_hop[54:40], zero pad
	input  logic [55:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[1:0], hop_out[16:2], zero pad
	output logic [23:0] m_tdata
);
	import btrie_pkg::*;

	localparam int AW   = $clog2(NODE_COUNT);
	localparam int CW   = AW + 1;
	localparam int DW   = 2 * AW + HOP_W + 1;
	localparam int LIM  = (MAX_PREFIX_LEN < ADDR_W) ? MAX_PREFIX_LEN : ADDR_W;
	localparam int PW   = $clog2(LIM + 1);
	localparam int DEPW = (PW > LEN_W) ? PW : LEN_W;
	localparam int PIW  = (LIM > 1) ? $clog2(LIM) : 1;

	state_t state_q, state_d;

	// item registers
	kind_t              kind_q;
	logic [ADDR_W-1:0]  bits_q;
	logic [DEPW-1:0]    len_q;
	logic [HOP_W-1:0]   hop_in_q;
	logic [DEPW-1:0]    i_q;
	logic [AW-1:0]      n_q;
	logic               pass2_q;
	logic               found_q;
	logic [HOP_W-1:0]   h_q;
	logic [CW-1:0]      free_cnt_q;
	logic [AW-1:0]      init_q;
	logic [1:0]         st_q;
	logic [HOP_W-1:0]   hop_res_q;
	logic               mvalid_q;
	// nodes at depth 1..LIM of the current walk, used by delete pruning, the root is implied
	logic [AW-1:0]      path_q [LIM];

	// node memory
	logic          nwe;
	logic [AW-1:0] nwaddr, nraddr;
	logic [DW-1:0] nwdata, nrdata;
	btrie_node_mem #(.DEPTH(NODE_COUNT), .AW(AW), .DW(DW)) u_mem (
		.clk(clk), .we(nwe), .waddr(nwaddr), .wdata(nwdata),
		.raddr(nraddr), .rdata(nrdata)
	);

	// free stack memory
	logic [AW-1:0] free_mem [NODE_COUNT];
	logic          fwe;
	logic [AW-1:0] fwaddr, fwdata, fraddr, frdata;
	always_ff @(posedge clk) begin
		if (fwe) begin
			free_mem[fwaddr] <= fwdata;
		end
		frdata <= free_mem[fraddr];
	end

	// node fields: {left, right, hop, valid}
	logic [AW-1:0]    r_left, r_right, r_child;
	logic [HOP_W-1:0] r_hop;
	logic             r_valid, cur_bit;
	assign r_left  = nrdata[DW-1 -: AW];
	assign r_right = nrdata[DW-1-AW -: AW];
	assign r_hop   = nrdata[HOP_W:1];
	assign r_valid = nrdata[0];

	logic [4:0] bidx;
	assign bidx    = 5'(ADDR_W - 1) - i_q[4:0];
	assign cur_bit = bits_q[bidx];
	assign r_child = cur_bit ? r_right : r_left;

	// length saturation on input
	logic [LEN_W-1:0] in_len;
	logic [DEPW-1:0]  eff_len;
	assign in_len  = s_tdata[39:34];
	assign eff_len = (32'(in_len) > LIM) ? DEPW'(LIM) : DEPW'(in_len);

	logic [CW-1:0] need;
	assign need = CW'(len_q - i_q);

	logic [DEPW-1:0] im1;
	assign im1 = i_q - 1'b1;
	logic [4:0] pbidx;
	assign pbidx = 5'(ADDR_W - 1) - im1[4:0];

	// path node at depth i and its parent at depth i-1
	logic [AW-1:0] path_cur, path_par;
	assign path_cur = path_q[PIW'(im1)];
	assign path_par = (im1 == '0) ? '0 : path_q[PIW'(im1 - 1'b1)];

	logic last_step;
	assign last_step = (i_q == len_q);

	assign s_tready = (state_q == S_IDLE) && !mvalid_q;
	assign m_tvalid = mvalid_q;
	assign m_tdata  = {7'd0, hop_res_q, st_q};

	// next state and memory controls
	always_comb begin
		state_d = state_q;
		nwe = 1'b0; nwaddr = n_q; nwdata = nrdata; nraddr = n_q;
		fwe = 1'b0; fwaddr = init_q; fwdata = '0; fraddr = AW'(free_cnt_q - 1'b1);
		case (state_q)
			S_INIT: begin
				nwe = 1'b1; nwaddr = init_q; nwdata = '0;
				fwe = 1'b1; fwaddr = init_q;
				fwdata = AW'(NODE_COUNT - 1) - init_q;
				if (init_q == AW'(NODE_COUNT - 1)) state_d = S_IDLE;
			end
			S_IDLE: begin
				nraddr = '0;
				if (s_tvalid && s_tready) begin
					state_d = (s_tdata[1:0] == KIND_NONE) ? S_DONE : S_WAIT;
				end
			end
			S_RD: state_d = S_WAIT;
			S_WAIT: state_d = S_STEP;
			S_STEP: begin
				if (kind_q == KIND_ADD && pass2_q) begin
					if (last_step) state_d = S_SETHOP;
					else if (r_child == '0) state_d = S_ALLOC;
					else state_d = S_RD;
				end else if (last_step || r_child == '0) begin
					if (kind_q == KIND_ADD)
						state_d = (!last_step && need > free_cnt_q) ? S_DONE : S_RD;
					else
						state_d = (kind_q == KIND_DELETE && last_step) ? S_SETHOP : S_DONE;
				end else begin
					state_d = S_RD;
				end
				// keep the current node in the read register unless moving down
				nraddr = (!last_step && r_child != '0) ? r_child : n_q;
			end
			S_ALLOC: begin
				// frdata holds the popped index; link it under the current node
				nwe = 1'b1; nwaddr = n_q;
				nwdata = nrdata;
				if (cur_bit) nwdata[DW-1-AW -: AW] = frdata;
				else nwdata[DW-1 -: AW] = frdata;
				state_d = S_RD;
			end
			S_SETHOP: begin
				nwe = 1'b1; nwaddr = n_q;
				nwdata = {r_left, r_right, (kind_q == KIND_ADD) ? hop_in_q : '0,
					kind_q == KIND_ADD};
				if (kind_q == KIND_ADD || !r_valid) state_d = S_DONE;
				else state_d = S_PRUNE_RD;
			end
			S_PRUNE_RD: begin
				nraddr = path_cur;
				state_d = (i_q == '0) ? S_DONE : S_PRUNE_WAIT;
			end
			S_PRUNE_WAIT: begin
				nraddr = path_cur;
				state_d = S_PRUNE_CHK;
			end
			S_PRUNE_CHK: begin
				nraddr = path_par;
				if (r_valid || r_left != '0 || r_right != '0) state_d = S_DONE;
				else state_d = S_PRUNE_PAR_WAIT;
			end
			S_PRUNE_PAR_WAIT: begin
				nraddr = path_par;
				state_d = S_PRUNE_PAR;
			end
			S_PRUNE_PAR: begin
				nwe = 1'b1; nwaddr = path_par;
				nwdata = nrdata;
				if (bits_q[pbidx]) nwdata[DW-1-AW -: AW] = '0;
				else nwdata[DW-1 -: AW] = '0;
				fwe = 1'b1; fwaddr = AW'(free_cnt_q); fwdata = path_cur;
				state_d = S_PRUNE_RD;
			end
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			init_q     <= '0;
			free_cnt_q <= CW'(NODE_COUNT - 1);
			mvalid_q   <= 1'b0;
			pass2_q    <= 1'b0;
			found_q    <= 1'b0;
		end else begin
			if (state_q == S_INIT) init_q <= init_q + 1'b1;
			if (m_tvalid && m_tready) mvalid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (s_tvalid && s_tready) begin
						kind_q   <= kind_t'(s_tdata[1:0]);
						bits_q   <= s_tdata[33:2];
						len_q    <= eff_len;
						hop_in_q <= s_tdata[54:40];
						i_q      <= '0;
						n_q      <= '0;
						pass2_q  <= 1'b0;
						found_q  <= 1'b0;
						h_q      <= '0;
						st_q     <= ST_NOTFOUND;
					end
				end
				S_STEP: begin
					// lookup tracks deepest valid hop
					if (r_valid) begin
						found_q <= 1'b1;
						h_q     <= r_hop;
					end
					if (kind_q == KIND_ADD && !pass2_q && (last_step || r_child == '0)) begin
						// an add that runs out of nodes stops before the second pass
						if (!last_step && need > free_cnt_q) begin
							st_q <= ST_FULL;
						end else begin
							pass2_q <= 1'b1;
							i_q <= '0;
							n_q <= '0;
						end
					end else if (kind_q == KIND_ADD && pass2_q && !last_step
						&& r_child == '0) begin
						free_cnt_q <= free_cnt_q - 1'b1;
					end else if (!last_step && r_child != '0) begin
						i_q <= i_q + 1'b1;
						n_q <= r_child;
						path_q[PIW'(i_q)] <= r_child;
					end else if (kind_q == KIND_LOOKUP) begin
						st_q <= (found_q || r_valid) ? ST_OK : ST_NOTFOUND;
						hop_res_q <= r_valid ? r_hop : (found_q ? h_q : '0);
					end
				end
				S_ALLOC: begin
					i_q <= i_q + 1'b1;
					n_q <= frdata;
					path_q[PIW'(i_q)] <= frdata;
				end
				S_SETHOP: begin
					if (kind_q == KIND_ADD || r_valid) st_q <= ST_OK;
				end
				S_PRUNE_PAR: begin
					free_cnt_q <= free_cnt_q + 1'b1;
					i_q <= im1;
				end
				S_DONE: begin
					mvalid_q <= 1'b1;
					if (kind_q != KIND_LOOKUP || st_q != ST_OK) hop_res_q <= '0;
				end
				default: ;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		free_cnt_q <= CW'(NODE_COUNT - 1)) else $error("free count overflow");
	assert property (@(posedge clk) disable iff (!arst_n)
		s_tready |-> !mvalid_q) else $error("ready while result pending");
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_ALLOC |-> free_cnt_q != CW'(NODE_COUNT - 1))
		else $error("allocation with full free stack");
endmodule

[rtl/btrie_node_mem.sv]
module btrie_node_mem #(
	parameter int DEPTH = 1024,
	parameter int AW    = 10,
	parameter int DW    = 36
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [DW-1:0] wdata,
	input  logic [AW-1:0] raddr,
	output logic [DW-1:0] rdata
);
	logic [DW-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
